// ===== sv/nfc_type4_tag_apdu_responder_assert.svh =====
// assertion macros shared by the responder rtl
`ifndef NFC_TYPE4_TAG_APDU_RESPONDER_ASSERT_SVH
`define NFC_TYPE4_TAG_APDU_RESPONDER_ASSERT_SVH

// same-cycle implication under active-low reset
`define NFCT4_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("nfct4 assertion failed");

// next-cycle implication under active-low reset
`define NFCT4_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("nfct4 assertion failed");

`endif

// ===== sv/nfct4_pkg.sv =====
`timescale 1ns / 1ps
package nfct4_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FETCH,
    ST_PACK
  } st_t;

  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_CC   = 2'd1,
    SEL_NDEF = 2'd2
  } sel_t;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_APDU  = 2'd1;
  localparam logic [1:0] CMD_HOST  = 2'd2;

  localparam logic REG_WRITE_ENABLE = 1'b0;
  localparam logic REG_MAX_LENGTH   = 1'b1;

  localparam logic [7:0] INS_SELECT = 8'hA4;
  localparam logic [7:0] INS_READ   = 8'hB0;
  localparam logic [7:0] INS_UPDATE = 8'hD6;

  localparam logic [7:0] P1_BY_ID   = 8'h00;
  localparam logic [7:0] P1_BY_NAME = 8'h04;
  localparam logic [7:0] P2_FIRST   = 8'h0C;

  localparam logic [7:0] FID_HI     = 8'hE1;
  localparam logic [7:0] FID_CC     = 8'h03;
  localparam logic [7:0] FID_NDEF   = 8'h04;

  localparam logic [15:0] SW_OK        = 16'h9000;
  localparam logic [15:0] SW_NOT_FOUND = 16'h6A82;
  localparam logic [15:0] SW_NOT_SUPP  = 16'h6A81;
  localparam logic [15:0] SW_MEM_FAIL  = 16'h6581;
  localparam logic [15:0] SW_EOF       = 16'h6282;

  // ndef application name bytes 3..11 of a select by name
  function automatic logic [7:0] app_name(input logic [3:0] k);
    logic [7:0] v;
    unique case (k)
      4'd0:    v = 8'h00;
      4'd1:    v = 8'h07;
      4'd2:    v = 8'hD2;
      4'd3:    v = 8'h76;
      4'd4:    v = 8'h00;
      4'd5:    v = 8'h00;
      4'd6:    v = 8'h85;
      4'd7:    v = 8'h01;
      4'd8:    v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // capability container contents
  function automatic logic [7:0] cc_byte(input logic [8:0] idx, input logic [7:0] mfl,
                                         input logic we);
    logic [7:0] v;
    unique case (idx)
      9'd1:    v = 8'h0F;
      9'd2:    v = 8'h20;
      9'd4:    v = 8'h54;
      9'd6:    v = 8'hFF;
      9'd7:    v = 8'h04;
      9'd8:    v = 8'h06;
      9'd9:    v = 8'hE1;
      9'd10:   v = 8'h04;
      9'd12:   v = mfl;
      9'd14:   v = we ? 8'h00 : 8'hFF;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/nfct4_if.sv =====
`timescale 1ns / 1ps
interface nfct4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;
  logic [6:0] store_address;
  logic       apdu_end;
  modport source (output valid, command, data_byte, store_address, apdu_end, input ready);
  modport sink (input valid, command, data_byte, store_address, apdu_end, output ready);
endinterface

interface nfct4_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] response_word;
  logic [2:0]  byte_count;
  logic        last_word;
  logic        file_updated;
  logic [15:0] file_length;
  logic        written_by_reader;
  modport source (output valid, response_word, byte_count, last_word, file_updated,
                  file_length, written_by_reader, input ready);
  modport sink (input valid, response_word, byte_count, last_word, file_updated,
                file_length, written_by_reader, output ready);
endinterface

// ===== sv/nfc_type4_tag_apdu_responder.sv =====
`timescale 1ns / 1ps
// channel   | dir | word contents
// in_ch     | in  | command, data_byte, store_address, apdu_end
// out_ch    | out | response_word, byte_count, last_word, file_updated, file_length,
//           |     | written_by_reader
// cfg_*     | in  | apb register port, write_enable at 0x0, max_file_length at 0x4
//
// one input word per cycle while idle; the final apdu byte leads into an evaluation state
// a response then steps through a store read and a pack for each byte, and the pack waits on
// output stalls; this order is set by the single read port of the store memory
// after reset the store is cleared one entry per cycle, all STORE_BYTES entries, input held off
// the last response word may wait in the output register while new input is taken
`include "nfc_type4_tag_apdu_responder_assert.svh"

module nfc_type4_tag_apdu_responder #(
  parameter int STORE_BYTES = 128,
  parameter int FRAME_BYTES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  nfct4_in_if.sink          in_ch,
  nfct4_out_if.source       out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int SA_W = $clog2(STORE_BYTES);
  localparam logic [16:0] STORE_LIM = 17'(STORE_BYTES);
  localparam logic [8:0] READ_MAX = 9'(FRAME_BYTES - 2);

  // configuration registers
  logic       we_r;
  logic [7:0] mfl_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      we_r  <= 1'b1;
      mfl_r <= 8'd128;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        nfct4_pkg::REG_WRITE_ENABLE: we_r  <= cfg_pwdata[0];
        nfct4_pkg::REG_MAX_LENGTH:   mfl_r <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      nfct4_pkg::REG_WRITE_ENABLE: cfg_prdata = {31'd0, we_r};
      nfct4_pkg::REG_MAX_LENGTH:   cfg_prdata = {24'd0, mfl_r};
      default:                     cfg_prdata = 32'd0;
    endcase
  end

  // file store memory, one write and one registered read port
  logic [7:0]      mem [STORE_BYTES];
  logic            mem_we;
  logic [SA_W-1:0] mem_wa;
  logic [7:0]      mem_wd;
  logic            mem_re;
  logic [SA_W-1:0] mem_ra;
  logic [7:0]      mem_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_r <= mem[mem_ra];
  end

  // clearing pass after reset
  logic            clr_busy_r;
  logic [SA_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == SA_W'(STORE_BYTES - 1)) clr_busy_r <= 1'b0;
    end
  end

  // control and apdu collection state
  nfct4_pkg::st_t  st_r, st_nxt;
  nfct4_pkg::sel_t sel_r, sel_nxt;
  logic            rw_r, rw_nxt;
  logic [7:0]      hdr_r [5];
  logic [7:0]      pos_r;
  logic [7:0]      id_r [2];
  logic            nm_r;
  logic [7:0]      len_hi_r, len_lo_r;

  // response sequencing
  logic [8:0]  len_r, len_nxt;
  logic [7:0]  param_r;
  logic [15:0] sw_r, sw_nxt;
  logic        upd_r, upd_nxt;
  logic [15:0] resp_flen_r;
  logic        resp_rw_r;
  logic [8:0]  j_r;
  logic [31:0] acc_r;
  logic [2:0]  cnt_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_cnt_r;
  logic        out_last_r;
  logic        out_upd_r;
  logic [15:0] out_flen_r;
  logic        out_rw_r;

  logic        acc_in;
  logic [15:0] param_w;
  logic        upd_hit;
  logic [7:0]  upd_i;
  logic [16:0] upd_a;
  logic [16:0] rd_a;
  logic        rd_inrng;
  logic [7:0]  pk_byte;
  logic        pk_last;
  logic        pk_full;
  logic        can_emit;
  logic        emit;
  logic [31:0] acc_new;

  assign in_ch.ready = (st_r == nfct4_pkg::ST_IDLE) && !clr_busy_r;
  assign acc_in = in_ch.valid && in_ch.ready;
  assign param_w = {hdr_r[2], hdr_r[3]};

  // update binary writes each data byte as it arrives
  assign upd_i = pos_r - 8'd5;
  assign upd_a = 17'(param_w) + 17'(upd_i);
  assign upd_hit = (pos_r != 8'hFF) && (pos_r >= 8'd5) &&
                   (hdr_r[1] == nfct4_pkg::INS_UPDATE) && we_r &&
                   (upd_i < hdr_r[4]) && (param_w <= {8'd0, mfl_r}) && (upd_a < STORE_LIM);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = 8'd0;
    if (clr_busy_r) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
    end else if (acc_in && in_ch.command == nfct4_pkg::CMD_HOST &&
                 17'(in_ch.store_address) < STORE_LIM) begin
      mem_we = 1'b1;
      mem_wa = SA_W'(in_ch.store_address);
      mem_wd = in_ch.data_byte;
    end else if (acc_in && in_ch.command == nfct4_pkg::CMD_APDU && upd_hit) begin
      mem_we = 1'b1;
      mem_wa = upd_a[SA_W-1:0];
      mem_wd = in_ch.data_byte;
    end
  end

  // read address of the current response byte
  assign rd_a = 17'(param_r) + 17'(j_r);
  assign rd_inrng = rd_a < STORE_LIM;
  assign mem_re = (st_r == nfct4_pkg::ST_FETCH) && (j_r < len_r) &&
                  (sel_r == nfct4_pkg::SEL_NDEF) && rd_inrng;
  assign mem_ra = rd_a[SA_W-1:0];

  // byte being packed
  always_comb begin
    if (j_r < len_r) begin
      if (sel_r == nfct4_pkg::SEL_CC) pk_byte = nfct4_pkg::cc_byte(rd_a[8:0], mfl_r, we_r);
      else pk_byte = rd_inrng ? mem_rd_r : 8'd0;
    end else if (j_r == len_r) begin
      pk_byte = sw_r[15:8];
    end else begin
      pk_byte = sw_r[7:0];
    end
  end

  assign pk_last  = (j_r == len_r + 9'd1);
  assign pk_full  = (cnt_r == 3'd3) || pk_last;
  assign can_emit = !out_valid_r || out_ch.ready;
  assign emit     = (st_r == nfct4_pkg::ST_PACK) && pk_full && can_emit;
  assign acc_new  = acc_r | ({24'd0, pk_byte} << (5'd24 - {cnt_r[1:0], 3'd0}));

  // evaluation of a complete apdu
  always_comb begin
    sw_nxt  = nfct4_pkg::SW_NOT_SUPP;
    len_nxt = 9'd0;
    upd_nxt = 1'b0;
    sel_nxt = sel_r;
    rw_nxt  = rw_r;
    unique case (hdr_r[1])
      nfct4_pkg::INS_SELECT: begin
        if (hdr_r[2] == nfct4_pkg::P1_BY_ID) begin
          if (hdr_r[3] != nfct4_pkg::P2_FIRST) begin
            sw_nxt = nfct4_pkg::SW_OK;
          end else if (hdr_r[4] == 8'd2 && pos_r >= 8'd7 && id_r[0] == nfct4_pkg::FID_HI &&
                       (id_r[1] == nfct4_pkg::FID_CC || id_r[1] == nfct4_pkg::FID_NDEF)) begin
            sw_nxt  = nfct4_pkg::SW_OK;
            sel_nxt = (id_r[1] == nfct4_pkg::FID_CC) ? nfct4_pkg::SEL_CC : nfct4_pkg::SEL_NDEF;
          end else begin
            sw_nxt = nfct4_pkg::SW_NOT_FOUND;
          end
        end else if (hdr_r[2] == nfct4_pkg::P1_BY_NAME) begin
          if (nm_r && pos_r >= 8'd12) sw_nxt = nfct4_pkg::SW_OK;
        end
      end
      nfct4_pkg::INS_READ: begin
        if (sel_r != nfct4_pkg::SEL_CC && sel_r != nfct4_pkg::SEL_NDEF) begin
          sw_nxt = nfct4_pkg::SW_NOT_FOUND;
        end else if (param_w > {8'd0, mfl_r}) begin
          sw_nxt = nfct4_pkg::SW_EOF;
        end else begin
          len_nxt = (9'(hdr_r[4]) > READ_MAX) ? READ_MAX : 9'(hdr_r[4]);
          sw_nxt  = nfct4_pkg::SW_OK;
        end
      end
      nfct4_pkg::INS_UPDATE: begin
        if (!we_r) begin
          sw_nxt = nfct4_pkg::SW_NOT_SUPP;
        end else if (param_w > {8'd0, mfl_r}) begin
          sw_nxt = nfct4_pkg::SW_MEM_FAIL;
        end else begin
          sw_nxt  = nfct4_pkg::SW_OK;
          rw_nxt  = 1'b1;
          upd_nxt = ({len_hi_r, len_lo_r} != 16'd0);
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      nfct4_pkg::ST_IDLE:
        if (acc_in && in_ch.command == nfct4_pkg::CMD_APDU && in_ch.apdu_end)
          st_nxt = nfct4_pkg::ST_EVAL;
      nfct4_pkg::ST_EVAL:  st_nxt = nfct4_pkg::ST_FETCH;
      nfct4_pkg::ST_FETCH: st_nxt = nfct4_pkg::ST_PACK;
      nfct4_pkg::ST_PACK:
        if (!pk_full || can_emit) st_nxt = pk_last ? nfct4_pkg::ST_IDLE : nfct4_pkg::ST_FETCH;
      default: st_nxt = nfct4_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= nfct4_pkg::ST_IDLE;
    else st_r <= st_nxt;
  end

  // session, collection and response registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r    <= nfct4_pkg::SEL_NONE;
      rw_r     <= 1'b0;
      pos_r    <= 8'd0;
      nm_r     <= 1'b1;
      hdr_r    <= '{default: 8'd0};
      id_r     <= '{default: 8'd0};
      len_hi_r <= 8'd0;
      len_lo_r <= 8'd0;
      j_r      <= 9'd0;
      cnt_r    <= 3'd0;
      acc_r    <= 32'd0;
    end else begin
      if (mem_we && mem_wa == SA_W'(0)) len_hi_r <= mem_wd;
      if (mem_we && mem_wa == SA_W'(1)) len_lo_r <= mem_wd;

      if (acc_in && in_ch.command == nfct4_pkg::CMD_START) begin
        sel_r <= nfct4_pkg::SEL_NONE;
        rw_r  <= 1'b0;
        pos_r <= 8'd0;
        nm_r  <= 1'b1;
        hdr_r <= '{default: 8'd0};
        id_r  <= '{default: 8'd0};
      end else if (acc_in && in_ch.command == nfct4_pkg::CMD_APDU && pos_r != 8'hFF) begin
        if (pos_r < 8'd5) hdr_r[pos_r[2:0]] <= in_ch.data_byte;
        if (pos_r == 8'd5) id_r[0] <= in_ch.data_byte;
        if (pos_r == 8'd6) id_r[1] <= in_ch.data_byte;
        if (pos_r >= 8'd3 && pos_r <= 8'd11 &&
            in_ch.data_byte != nfct4_pkg::app_name(4'(pos_r - 8'd3)))
          nm_r <= 1'b0;
        pos_r <= pos_r + 8'd1;
      end

      if (st_r == nfct4_pkg::ST_EVAL) begin
        sel_r   <= sel_nxt;
        rw_r    <= rw_nxt;
        pos_r   <= 8'd0;
        nm_r    <= 1'b1;
        hdr_r   <= '{default: 8'd0};
        id_r    <= '{default: 8'd0};
        j_r     <= 9'd0;
        cnt_r   <= 3'd0;
        acc_r   <= 32'd0;
      end

      if (st_r == nfct4_pkg::ST_PACK && (!pk_full || can_emit)) begin
        j_r <= j_r + 9'd1;
        if (pk_full) begin
          cnt_r <= 3'd0;
          acc_r <= 32'd0;
        end else begin
          cnt_r <= cnt_r + 3'd1;
          acc_r <= acc_new;
        end
      end
    end
  end

  // response parameters latched at evaluation
  always_ff @(posedge clk) begin
    if (st_r == nfct4_pkg::ST_EVAL) begin
      len_r       <= len_nxt;
      param_r     <= hdr_r[3];
      sw_r        <= sw_nxt;
      upd_r       <= upd_nxt;
      resp_flen_r <= {len_hi_r, len_lo_r};
      resp_rw_r   <= rw_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // whole word captured at emit so a waiting word stays put
  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r <= acc_new;
      out_cnt_r  <= cnt_r + 3'd1;
      out_last_r <= pk_last;
      out_upd_r  <= upd_r;
      out_flen_r <= resp_flen_r;
      out_rw_r   <= resp_rw_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.response_word     = out_word_r;
  assign out_ch.byte_count        = out_cnt_r;
  assign out_ch.last_word         = out_last_r;
  assign out_ch.file_updated      = out_upd_r;
  assign out_ch.file_length       = out_flen_r;
  assign out_ch.written_by_reader = out_rw_r;

  // a pending word is never overwritten
  `NFCT4_ASSERT_IMP(a_no_overwrite, clk, rst_n, emit && out_valid_r, out_ch.ready)
  // the status word closes the response and frees the input side
  `NFCT4_ASSERT_NXT(a_last_idle, clk, rst_n, emit && pk_last, st_r == nfct4_pkg::ST_IDLE)
  // no input is taken while the store is being cleared
  `NFCT4_ASSERT_IMP(a_clr_block, clk, rst_n, clr_busy_r, !in_ch.ready)
  // a shown word always carries one to four bytes
  `NFCT4_ASSERT_IMP(a_cnt_range, clk, rst_n, out_valid_r,
                    out_cnt_r != 3'd0 && out_cnt_r <= 3'd4)

endmodule
